FILE: sv/hdlc_bit_unstuffer_core_macros.svh
// Assertion helpers for the HDLC bit unstuffer.
// Both sample on aclk and are held off while aresetn is low.
`ifndef HDLC_BIT_UNSTUFFER_CORE_MACROS_SVH
`define HDLC_BIT_UNSTUFFER_CORE_MACROS_SVH

// Same-cycle implication.
`define HBU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HBU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/hdlc_bu_pkg.sv
package hdlc_bu_pkg;

    // Run-count codes that change how a bit is treated
    localparam logic [2:0] RUN_STUFF = 3'd5;
    localparam logic [2:0] RUN_SIX   = 3'd6;

    // Input request payload
    typedef struct packed {
        logic       frame_start;
        logic [7:0] in_byte;
    } hdlc_bu_in_t;

    // Result request payload
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       flag_seen;
        logic       abort_seen;
    } hdlc_bu_out_t;

    // Decoder state as seen by the current byte (frame_start already applied)
    typedef struct packed {
        logic       aborted;
        logic [2:0] ones_run;
    } hdlc_bu_state_t;

    // Per-byte scan result
    typedef struct packed {
        logic [7:0] data;
        logic [3:0] ndata;
        logic       flag;
        logic       abrt;
        logic [2:0] run;
    } hdlc_bu_scan_t;

endpackage

FILE: sv/hdlc_bit_unstuffer_core.sv
// HDLC receive bit unstuffer.
// Input channel s_valid/s_ready/s_data carries one stuffed byte per request,
// earliest bit in bit 0, plus a frame_start bit that clears the run count,
// the bit packer and the abort state before that byte is decoded.
// Result channel m_valid/m_ready/m_data returns exactly one request per
// input request: byte_valid/out_byte when eight data bits have gathered,
// flag_seen when a flag completed within the byte, abort_seen after seven
// ones (sticky until the next frame_start).
// A request taken into the input register is decoded by the bit walk and
// packer into the result register once that register is free or draining.
// Throughput is one byte per cycle while the receiver does not stall; the
// run-count and carry registers close their loop through combinational decode logic.
// When the receiver stalls, the result register holds and the input
// register keeps taking one more request; after that s_ready drops until
// the result is taken.
// Reset (aresetn low, synchronous) empties both registers and clears the
// decode state; no request is lost or repeated across a stall.
module hdlc_bit_unstuffer_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  hdlc_bu_pkg::hdlc_bu_in_t  s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output hdlc_bu_pkg::hdlc_bu_out_t m_data
);

    `include "hdlc_bit_unstuffer_core_macros.svh"

    logic                        in_valid_reg;
    hdlc_bu_pkg::hdlc_bu_in_t    in_data_reg;
    logic                        m_valid_reg;
    hdlc_bu_pkg::hdlc_bu_out_t   m_data_reg;

    logic                        advance;
    hdlc_bu_pkg::hdlc_bu_state_t st;
    hdlc_bu_pkg::hdlc_bu_scan_t  scan;
    hdlc_bu_pkg::hdlc_bu_out_t   result;

    // Decode when a byte is held and the result slot is free or draining
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Bit walk
    hdlc_bu_scan u_scan (
        .in_byte (in_data_reg.in_byte),
        .run_in  (st.ones_run),
        .scan    (scan)
    );

    // Packer and decode state
    hdlc_bu_packer u_packer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .frame_start (in_data_reg.frame_start),
        .scan        (scan),
        .st          (st),
        .result      (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= result;
        end
    end

    // Checks
    `HBU_ASSERT_IMPL(a_run_range, 1'b1, st.ones_run <= hdlc_bu_pkg::RUN_SIX, "run out of range")
    `HBU_ASSERT_IMPL(a_abort_no_byte, m_valid && m_data.abort_seen, !m_data.byte_valid,
        "byte emitted with abort")
    `HBU_ASSERT_IMPL(a_idle_byte_zero, m_valid && !m_data.byte_valid, m_data.out_byte == 8'd0,
        "out_byte nonzero without byte_valid")
    `HBU_ASSERT_NEXT(a_decode_fills, advance, m_valid, "decoded byte not presented")

endmodule

FILE: sv/hdlc_bu_scan.sv
module hdlc_bu_scan (
    input  logic [7:0]              in_byte,
    input  logic [2:0]              run_in,
    output hdlc_bu_pkg::hdlc_bu_scan_t scan
);

    // Walk the eight bits LSB first: drop stuff bits, spot flags and aborts
    always_comb begin
        logic [2:0] run;
        logic [7:0] data;
        logic [3:0] ndata;
        logic       flag;
        logic       stop;
        run   = (run_in > hdlc_bu_pkg::RUN_SIX) ? hdlc_bu_pkg::RUN_SIX : run_in;
        data  = 8'd0;
        ndata = 4'd0;
        flag  = 1'b0;
        stop  = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (!stop) begin
                if (run == hdlc_bu_pkg::RUN_STUFF) begin
                    run = in_byte[b] ? hdlc_bu_pkg::RUN_SIX : 3'd0;
                end else if (run == hdlc_bu_pkg::RUN_SIX) begin
                    if (!in_byte[b]) begin
                        flag = 1'b1;
                        run  = 3'd0;
                    end else begin
                        stop = 1'b1;
                    end
                end else begin
                    data[ndata[2:0]] = in_byte[b];
                    ndata            = ndata + 4'd1;
                    run              = in_byte[b] ? run + 3'd1 : 3'd0;
                end
            end
        end
        scan.data  = data;
        scan.ndata = ndata;
        scan.flag  = flag;
        scan.abrt  = stop;
        scan.run   = run;
    end

endmodule

FILE: sv/hdlc_bu_packer.sv
module hdlc_bu_packer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic                         frame_start,
    input  hdlc_bu_pkg::hdlc_bu_scan_t   scan,
    output hdlc_bu_pkg::hdlc_bu_state_t  st,
    output hdlc_bu_pkg::hdlc_bu_out_t    result
);

    logic [2:0]  ones_run_reg,    ones_run_next;
    logic [6:0]  carry_bits_reg,  carry_bits_next;
    logic [2:0]  carry_count_reg, carry_count_next;
    logic        aborted_reg,     aborted_next;

    logic [6:0]  carry_eff;
    logic [2:0]  count_eff;
    logic [14:0] acc;
    logic [3:0]  total;

    // frame_start clears state ahead of this byte
    assign st.ones_run = frame_start ? 3'd0 : ones_run_reg;
    assign st.aborted  = frame_start ? 1'b0 : aborted_reg;
    assign carry_eff   = frame_start ? 7'd0 : carry_bits_reg;
    assign count_eff   = frame_start ? 3'd0 : carry_count_reg;

    // Append data bits behind the carry
    assign acc   = {8'd0, carry_eff} | ({7'd0, scan.data} << count_eff);
    assign total = {1'b0, count_eff} + scan.ndata;

    // Result and next state
    always_comb begin
        result           = '0;
        ones_run_next    = st.ones_run;
        carry_bits_next  = carry_eff;
        carry_count_next = count_eff;
        aborted_next     = st.aborted;
        if (st.aborted) begin
            result.abort_seen = 1'b1;
        end else if (scan.abrt) begin
            result.flag_seen  = scan.flag;
            result.abort_seen = 1'b1;
            aborted_next      = 1'b1;
            ones_run_next     = 3'd0;
            carry_bits_next   = 7'd0;
            carry_count_next  = 3'd0;
        end else begin
            result.flag_seen = scan.flag;
            ones_run_next    = scan.run;
            if (total[3]) begin
                result.byte_valid = 1'b1;
                result.out_byte   = acc[7:0];
                carry_bits_next   = acc[14:8];
            end else begin
                carry_bits_next   = acc[6:0];
            end
            carry_count_next = total[2:0];
        end
    end

    // State registers, updated once per processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ones_run_reg    <= 3'd0;
            carry_bits_reg  <= 7'd0;
            carry_count_reg <= 3'd0;
            aborted_reg     <= 1'b0;
        end else if (advance) begin
            ones_run_reg    <= ones_run_next;
            carry_bits_reg  <= carry_bits_next;
            carry_count_reg <= carry_count_next;
            aborted_reg     <= aborted_next;
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam logic [7:0]  FLAG_OCTET     = 8'h7E;

    logic                      aclk    = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    hdlc_bu_pkg::hdlc_bu_in_t  s_data  = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    hdlc_bu_pkg::hdlc_bu_out_t m_data;

    hdlc_bit_unstuffer_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Predicted decoder state
    logic [2:0] ones_count    = '0;
    logic [6:0] pack_bits     = '0;
    logic [2:0] pack_len      = '0;
    logic       frame_aborted = 1'b0;

    hdlc_bu_pkg::hdlc_bu_out_t expected_results [$];
    bit                        link_bits [$];
    hdlc_bu_pkg::hdlc_bu_out_t want_res;

    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned starts_sent    = 0;
    int unsigned flags_pred     = 0;
    int unsigned aborts_pred    = 0;
    int unsigned bytes_pred     = 0;
    int unsigned burst_left     = 0;
    int unsigned quiet_cycles   = 0;

    logic [6:0] stall_phase = '0;
    logic [1:0] stall_mode  = '0;

    // Decode one stuffed byte against the predicted state
    function automatic hdlc_bu_pkg::hdlc_bu_out_t unstuff_byte(hdlc_bu_pkg::hdlc_bu_in_t req);
        hdlc_bu_pkg::hdlc_bu_out_t res;
        logic [2:0]   run;
        logic [7:0]   data;
        logic [3:0]   ndata;
        logic [14:0]  acc;
        int unsigned  total;
        logic         hit_abort;
        res       = '0;
        data      = '0;
        ndata     = 4'd0;
        hit_abort = 1'b0;
        if (req.frame_start) begin
            ones_count    = '0;
            pack_bits     = '0;
            pack_len      = '0;
            frame_aborted = 1'b0;
        end
        if (frame_aborted) begin
            res.abort_seen = 1'b1;
            return res;
        end
        run = ones_count;
        for (int b = 0; b < 8 && !hit_abort; b++) begin
            if (run == hdlc_bu_pkg::RUN_STUFF) begin
                // stuff zero dropped, or sixth one held back
                run = req.in_byte[b] ? hdlc_bu_pkg::RUN_SIX : 3'd0;
            end else if (run == hdlc_bu_pkg::RUN_SIX) begin
                if (!req.in_byte[b]) begin
                    res.flag_seen = 1'b1;
                    run = '0;
                end else begin
                    hit_abort = 1'b1;
                end
            end else begin
                data[ndata[2:0]] = req.in_byte[b];
                ndata++;
                run = req.in_byte[b] ? run + 3'd1 : 3'd0;
            end
        end
        if (hit_abort) begin
            frame_aborted  = 1'b1;
            ones_count     = '0;
            pack_bits      = '0;
            pack_len       = '0;
            res.abort_seen = 1'b1;
            return res;
        end
        ones_count = run;
        // append data bits to the carry; emit a byte once eight have gathered
        acc   = 15'(pack_bits) | (15'(data) << pack_len);
        total = pack_len + ndata;
        if (total >= 8) begin
            res.byte_valid = 1'b1;
            res.out_byte   = acc[7:0];
            acc            = acc >> 8;
            total          = total - 8;
        end
        pack_bits = acc[6:0];
        pack_len  = total[2:0];
        return res;
    endfunction

    // Send one request in bursts with random gaps, then log its expected result
    task automatic send_request(input logic [7:0] byte_in, input logic start_in);
        hdlc_bu_pkg::hdlc_bu_in_t  req;
        hdlc_bu_pkg::hdlc_bu_out_t res;
        req.frame_start = start_in;
        req.in_byte     = byte_in;
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        res = unstuff_byte(req);
        expected_results.push_back(res);
        burst_left--;
        items_sent++;
        starts_sent += start_in;
        flags_pred  += res.flag_seen;
        aborts_pred += res.abort_seen;
        bytes_pred  += res.byte_valid;
    endtask

    // Hold the sender off until every outstanding result has come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    function automatic void add_flag();
        for (int i = 0; i < 8; i++) link_bits.push_back(FLAG_OCTET[i]);
    endfunction

    task automatic test_directed_cases();
        logic [8:0] cases [] = '{
            {1'b1, 8'h00},  // all zeros, one full byte
            {1'b0, 8'h55},
            {1'b0, 8'hAA},
            {1'b0, 8'h1F},  // a carried one plus five ones, so the zero completes a flag
            {1'b0, 8'h7E},  // flag inside a frame, packer keeps going
            {1'b0, 8'h3E},  // stuff zero after a run of five
            {1'b0, 8'hFC},  // ends with the run at six
            {1'b0, 8'hFE},  // flag, then seventh one in the same byte
            {1'b0, 8'h00},  // silent while aborted
            {1'b0, 8'h7E},
            {1'b1, 8'h7E},  // frame start clears the abort
            {1'b0, 8'h0F},  // leaves residual bits in the carry
            {1'b1, 8'h3C},  // residual bits dropped at frame start
            {1'b1, 8'hFF},  // abort within the first byte
            {1'b0, 8'hFF},
            {1'b1, 8'hF8},  // run of five across the byte boundary
            {1'b0, 8'h00},  // leading stuff zero dropped
            {1'b1, 8'hFC},
            {1'b0, 8'h01},  // seventh one at bit 0
            {1'b0, 8'h00},
            {1'b1, 8'hFF},
            {1'b1, 8'h00}
        };
        foreach (cases[i]) send_request(cases[i][7:0], cases[i][8]);
        wait_for_results();
    endtask

    // Well-formed stuffed frames between flags, some closed by an abort
    task automatic test_framed_traffic(input int unsigned n_items);
        int unsigned start_count;
        int unsigned n_frames;
        int unsigned n_bits;
        int unsigned ones;
        logic [7:0]  octet;
        logic        restart;
        bit          dense;
        bit          d;
        start_count = items_sent;
        while (items_sent - start_count < n_items) begin
            link_bits.delete();
            n_frames = $urandom_range(1, 4);
            for (int f = 0; f < n_frames; f++) begin
                add_flag();
                dense  = ($urandom_range(0, 1) == 1);
                n_bits = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 600)
                                                      : $urandom_range(0, 96);
                ones   = 0;
                for (int i = 0; i < n_bits; i++) begin
                    d = dense ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
                    link_bits.push_back(d);
                    ones = d ? ones + 1 : 0;
                    if (ones == 5) begin
                        link_bits.push_back(1'b0);
                        ones = 0;
                    end
                end
            end
            add_flag();
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(7, 12)) link_bits.push_back(1'b1);
            end
            // chop into bytes, padding the tail with random bits
            restart = ($urandom_range(0, 3) != 0);
            while (link_bits.size() != 0) begin
                for (int b = 0; b < 8; b++) begin
                    octet[b] = (link_bits.size() != 0) ? link_bits.pop_front()
                                                        : 1'($urandom_range(0, 1));
                end
                send_request(octet, restart);
                restart = 1'b0;
            end
        end
        wait_for_results();
    endtask

    // Unstructured bytes, mixed ones density, sparse frame starts
    task automatic test_random_bytes(input int unsigned n_items);
        logic [7:0] octet;
        repeat (n_items) begin
            case ($urandom_range(0, 2))
                0:       octet = 8'($urandom);
                1:       octet = 8'($urandom | $urandom);
                default: octet = 8'($urandom & $urandom);
            endcase
            send_request(octet, $urandom_range(0, 15) == 0);
        end
        wait_for_results();
    endtask

    // Receiver ready pattern, mode changes whenever the 7-bit phase counter wraps
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 7'd1;
        if (stall_phase == '0) begin
            stall_mode <= 2'($urandom_range(0, 3));
        end
        case (stall_mode)
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= 1'($urandom_range(0, 1));
            2'd2:    m_ready <= (stall_phase[1:0] != 2'b11);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: %p", m_data);
                mismatch_count++;
            end else begin
                want_res = expected_results.pop_front();
                if (m_data.byte_valid !== want_res.byte_valid) begin
                    $error("byte_valid: expected %0b, got %0b",
                           want_res.byte_valid, m_data.byte_valid);
                    mismatch_count++;
                end
                if (m_data.out_byte !== want_res.out_byte) begin
                    $error("out_byte: expected %h, got %h",
                           want_res.out_byte, m_data.out_byte);
                    mismatch_count++;
                end
                if (m_data.flag_seen !== want_res.flag_seen) begin
                    $error("flag_seen: expected %0b, got %0b",
                           want_res.flag_seen, m_data.flag_seen);
                    mismatch_count++;
                end
                if (m_data.abort_seen !== want_res.abort_seen) begin
                    $error("abort_seen: expected %0b, got %0b",
                           want_res.abort_seen, m_data.abort_seen);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles where no request moves
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $error("no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("hdlc_bit_unstuffer_core regression: fail");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_framed_traffic(1200);
        test_random_bytes(450);

        s_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d requests (%0d frame starts) over stuffed frames and noise,",
                 items_sent, starts_sent);
        $display("with %0d data bytes, %0d flags and %0d abort results predicted.",
                 bytes_pred, flags_pred, aborts_pred);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("hdlc_bit_unstuffer_core regression: pass");
        end else begin
            $display("hdlc_bit_unstuffer_core regression: fail");
        end
        $finish;
    end

endmodule
